@@ hw/rtl/linear_interp_resampler_assert.svh @@
// Assertion helpers; the calling scope must provide clk and rst_n.
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LIR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("resampler assertion failed");

// Consequent checked in the cycle after the antecedent.
`define LIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resampler assertion failed");

`endif

@@ hw/rtl/lir_pkg.sv @@
`timescale 1ns / 1ps
package lir_pkg;

  localparam int LANES            = 8;
  localparam int MAX_CHANNELS     = 8;
  localparam int SAMPLE_BITS      = 16;
  localparam int FRAME_COUNT_BITS = 24;
  localparam int EMIT_BITS        = FRAME_COUNT_BITS + 4;
  localparam int FRAC_BITS        = 32;
  localparam int POS_BITS         = FRAME_COUNT_BITS + FRAC_BITS;
  localparam int STEP_BITS        = 40;
  localparam int SRC_BITS         = 18;
  localparam int TGT_BITS         = 16;
  localparam int CHN_BITS         = 4;
  localparam int RESULT_CAP       = 8;
  localparam int RESULT_CNT_BITS  = $clog2(RESULT_CAP + 1);
  localparam int PROD_A_BITS      = EMIT_BITS + SRC_BITS;
  localparam int PROD_B_BITS      = FRAME_COUNT_BITS + TGT_BITS;

  localparam logic [SRC_BITS-1:0] SRC_RATE_MIN = SRC_BITS'(8000);
  localparam logic [SRC_BITS-1:0] SRC_RATE_MAX = SRC_BITS'(192000);
  localparam logic [TGT_BITS-1:0] TGT_RATE_MIN = TGT_BITS'(8000);
  localparam logic [TGT_BITS-1:0] TGT_RATE_MAX = TGT_BITS'(48000);

  localparam logic signed [SAMPLE_BITS+1:0] SAMPLE_MIN = -18'sd32768;
  localparam logic signed [SAMPLE_BITS+1:0] SAMPLE_MAX = 18'sd32767;

  localparam int REG_IDX_BITS = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_IN_RATE       = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_OUT_RATE      = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;

  typedef logic [LANES-1:0][SAMPLE_BITS-1:0] lir_frame_t;

  typedef struct packed {
    lir_frame_t                  ch;
    logic                        fin;
    logic [FRAME_COUNT_BITS-1:0] idx;
  } lir_item_t;

  typedef struct packed {
    logic [1:0]                  fill;
    logic [FRAME_COUNT_BITS-1:0] frames_seen;
  } lir_front_stat_t;

endpackage

@@ hw/rtl/linear_interp_resampler.sv @@
`timescale 1ns / 1ps
// Linear-interpolation sample-rate converter for interleaved 16-bit PCM frames.
// Input channel: one frame per item (in_ch0..in_ch7, in_final_frame), taken when
// in_valid is high and in_stall low. A two-entry queue sits in front of the engine.
// Output channel: resampled frames on out_ch0..out_ch7, out_run_last marks the last
// frame an input caused, out_clip_done the last frame of the clip.
// Input rate at 0x0, output rate at 0x4, channel count at 0x8 (APB); write them
// only while no item is in flight.
// Each frame runs a closing hit test, and each interpolated output it makes runs the
// hit test, lane multiply, mix and clamp. The final frame adds the closing held-end
// test and a held-end test per held-end output. The first frame of a clip runs the
// step divider (two quotient bits a cycle) instead, plus the held-end steps when it
// is also final.
// Each output is held one step in the holding register so the last of its input
// can be flagged. While out_stall is high the engine parks one output in the
// holding register and waits; the queue keeps taking items until full.
// Reset clears all counters, the previous frame and the step; registers return
// to 44100 Hz in, 48000 Hz out, two channels. No memory needs clearing.
module linear_interp_resampler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lir_pkg::REG_IDX_BITS+1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              in_ch0,
  input  logic signed [15:0]              in_ch1,
  input  logic signed [15:0]              in_ch2,
  input  logic signed [15:0]              in_ch3,
  input  logic signed [15:0]              in_ch4,
  input  logic signed [15:0]              in_ch5,
  input  logic signed [15:0]              in_ch6,
  input  logic signed [15:0]              in_ch7,
  input  logic                            in_final_frame,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [15:0]              out_ch0,
  output logic signed [15:0]              out_ch1,
  output logic signed [15:0]              out_ch2,
  output logic signed [15:0]              out_ch3,
  output logic signed [15:0]              out_ch4,
  output logic signed [15:0]              out_ch5,
  output logic signed [15:0]              out_ch6,
  output logic signed [15:0]              out_ch7,
  output logic                            out_run_last,
  output logic                            out_clip_done
);
  import lir_pkg::*;

  logic [SRC_BITS-1:0]     src_r;
  logic [TGT_BITS-1:0]     tgt_r;
  logic [CHN_BITS-1:0]     chn_r;
  logic [SRC_BITS-1:0]     src_c;
  logic [TGT_BITS-1:0]     tgt_c;
  logic [CHN_BITS-1:0]     chans_c;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    wr_en;

  logic                    q_valid;
  logic                    q_pop;
  lir_item_t               q_item;
  lir_front_stat_t         front_stat;
  lir_frame_t              out_data;

  logic                        in_acc;
  logic [FRAME_COUNT_BITS-1:0] seen_cnt;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_IDX_BITS+1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= SRC_BITS'(44100);
      tgt_r <= TGT_BITS'(48000);
      chn_r <= CHN_BITS'(2);
    end else if (wr_en) begin
      case (reg_idx)
        REG_IN_RATE:       src_r <= pwdata[SRC_BITS-1:0];
        REG_OUT_RATE:      tgt_r <= pwdata[TGT_BITS-1:0];
        REG_CHANNEL_COUNT: chn_r <= pwdata[CHN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IN_RATE:       prdata = 32'(src_r);
      REG_OUT_RATE:      prdata = 32'(tgt_r);
      REG_CHANNEL_COUNT: prdata = 32'(chn_r);
      default:           prdata = '0;
    endcase
  end

  // Out-of-range register values are pulled into range before use.
  always_comb begin
    src_c   = (src_r < SRC_RATE_MIN) ? SRC_RATE_MIN :
              (src_r > SRC_RATE_MAX) ? SRC_RATE_MAX : src_r;
    tgt_c   = (tgt_r < TGT_RATE_MIN) ? TGT_RATE_MIN :
              (tgt_r > TGT_RATE_MAX) ? TGT_RATE_MAX : tgt_r;
    chans_c = (chn_r == '0) ? CHN_BITS'(1) :
              (chn_r > CHN_BITS'(MAX_CHANNELS)) ? CHN_BITS'(MAX_CHANNELS) : chn_r;
  end

  lir_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch0         (in_ch0),
    .in_ch1         (in_ch1),
    .in_ch2         (in_ch2),
    .in_ch3         (in_ch3),
    .in_ch4         (in_ch4),
    .in_ch5         (in_ch5),
    .in_ch6         (in_ch6),
    .in_ch7         (in_ch7),
    .in_final_frame (in_final_frame),
    .q_pop          (q_pop),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .stat           (front_stat)
  );

  lir_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .src_rate      (src_c),
    .tgt_rate      (tgt_c),
    .chans         (chans_c),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .out_run_last  (out_run_last),
    .out_clip_done (out_clip_done)
  );

  assign out_ch0 = $signed(out_data[0]);
  assign out_ch1 = $signed(out_data[1]);
  assign out_ch2 = $signed(out_data[2]);
  assign out_ch3 = $signed(out_data[3]);
  assign out_ch4 = $signed(out_data[4]);
  assign out_ch5 = $signed(out_data[5]);
  assign out_ch6 = $signed(out_data[6]);
  assign out_ch7 = $signed(out_data[7]);

  assign in_acc   = in_valid && !in_stall;
  assign seen_cnt = front_stat.frames_seen;

`include "linear_interp_resampler_assert.svh"

  `LIR_ASSERT_SAME(a_unused_lane_zero, out_valid && (chans_c < CHN_BITS'(LANES)), out_ch7 == 16'sd0)
  `LIR_ASSERT_SAME(a_queue_bound, 1'b1, front_stat.fill <= 2'd2)
  `LIR_ASSERT_NEXT(a_clip_restart, in_acc && in_final_frame, seen_cnt == '0)
  `LIR_ASSERT_NEXT(a_frame_count, in_acc && !in_final_frame, seen_cnt == $past(seen_cnt) + 1'b1)

endmodule

@@ hw/rtl/lir_div.sv @@
`timescale 1ns / 1ps
module lir_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lir_pkg::SRC_BITS-1:0]  src_rate,
  input  logic [lir_pkg::TGT_BITS-1:0]  tgt_rate,
  output logic                          done,
  output logic [lir_pkg::STEP_BITS-1:0] quot
);
  import lir_pkg::*;

  localparam int DVD_BITS = SRC_BITS + FRAC_BITS;
  localparam int PER_CYC  = 2;
  localparam int ITERS    = DVD_BITS / PER_CYC;
  localparam int CNT_BITS = $clog2(ITERS);

  logic [DVD_BITS-1:0]  dvd_r;
  logic [TGT_BITS-1:0]  rem_r;
  logic [TGT_BITS-1:0]  dsr_r;
  logic [STEP_BITS-1:0] quo_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DVD_BITS-1:0]  dvd_nxt;
  logic [TGT_BITS-1:0]  rem_nxt;
  logic [STEP_BITS-1:0] quo_nxt;

  // Restoring divide, two quotient bits a cycle; remainder stays below the divisor.
  always_comb begin
    logic [TGT_BITS:0] trial;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int b = 0; b < PER_CYC; b++) begin
      trial   = {rem_nxt, dvd_nxt[DVD_BITS-1]};
      dvd_nxt = {dvd_nxt[DVD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = TGT_BITS'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_nxt[STEP_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[TGT_BITS-1:0];
        quo_nxt = {quo_nxt[STEP_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(ITERS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {src_rate, FRAC_BITS'(0)};
      dsr_r <= tgt_rate;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

@@ hw/rtl/lir_front.sv @@
`timescale 1ns / 1ps
module lir_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            in_ch0,
  input  logic signed [15:0]            in_ch1,
  input  logic signed [15:0]            in_ch2,
  input  logic signed [15:0]            in_ch3,
  input  logic signed [15:0]            in_ch4,
  input  logic signed [15:0]            in_ch5,
  input  logic signed [15:0]            in_ch6,
  input  logic signed [15:0]            in_ch7,
  input  logic                          in_final_frame,
  input  logic                          q_pop,
  output logic                          q_valid,
  output lir_pkg::lir_item_t            q_item,
  output lir_pkg::lir_front_stat_t      stat
);
  import lir_pkg::*;

  localparam int QDEPTH = 2;

  lir_item_t                   queue_r [QDEPTH];
  logic                        wr_ptr_r;
  logic                        rd_ptr_r;
  logic [1:0]                  fill_r;
  logic [FRAME_COUNT_BITS-1:0] frames_seen_r;
  lir_item_t                   new_item;
  logic                        push;

  assign in_stall = (fill_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;

  // Each item carries its frame index within the clip.
  always_comb begin
    new_item.ch  = {in_ch7, in_ch6, in_ch5, in_ch4, in_ch3, in_ch2, in_ch1, in_ch0};
    new_item.fin = in_final_frame;
    new_item.idx = frames_seen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r      <= 1'b0;
      rd_ptr_r      <= 1'b0;
      fill_r        <= '0;
      frames_seen_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r      <= !wr_ptr_r;
        frames_seen_r <= in_final_frame ? '0 : frames_seen_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, q_pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_item;
    end
  end

  assign q_valid          = (fill_r != '0);
  assign q_item           = queue_r[rd_ptr_r];
  assign stat.fill        = fill_r;
  assign stat.frames_seen = frames_seen_r;

endmodule

@@ hw/rtl/lir_back.sv @@
`timescale 1ns / 1ps
module lir_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  lir_pkg::lir_item_t           q_item,
  output logic                         q_pop,
  input  logic [lir_pkg::SRC_BITS-1:0] src_rate,
  input  logic [lir_pkg::TGT_BITS-1:0] tgt_rate,
  input  logic [lir_pkg::CHN_BITS-1:0] chans,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lir_pkg::lir_frame_t          out_data,
  output logic                         out_run_last,
  output logic                         out_clip_done
);
  import lir_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_DIV, B_IMUL, B_ITEST, B_LMUL, B_LOUT, B_HMUL, B_HTEST, B_HOUT, B_FIN
  } bstate_t;

  bstate_t                     state_r;
  logic signed [15:0]          cur_r   [LANES];
  logic signed [15:0]          prev_r  [LANES];
  logic signed [49:0]          lane_r  [LANES];
  lir_frame_t                  pend_r;
  logic                        pend_valid_r;
  lir_frame_t                  out_data_r;
  logic                        out_valid_r;
  logic                        out_run_last_r;
  logic                        out_clip_done_r;
  logic                        fin_r;
  logic [FRAME_COUNT_BITS-1:0] k_r;
  logic [RESULT_CNT_BITS-1:0]  n_r;
  logic [POS_BITS-1:0]         rp_r;
  logic [STEP_BITS-1:0]        step_r;
  logic [EMIT_BITS-1:0]        fe_r;
  logic [PROD_A_BITS-1:0]      prod_a_r;
  logic [PROD_B_BITS-1:0]      prod_b_r;
  logic                        fe_zero_r;

  logic                        div_start;
  logic                        div_done;
  logic [STEP_BITS-1:0]        div_quot;

  logic signed [16:0]          diff_w [LANES];
  logic signed [49:0]          mult_w [LANES];
  logic signed [32:0]          frac_w;
  lir_frame_t                  res_w;
  logic [FRAME_COUNT_BITS-1:0] want_w;
  logic                        pos_hit_w;
  logic                        held_ok_w;
  logic                        cap_ok_w;
  logic                        can_load_w;
  logic                        push_ok_w;
  logic                        out_load_w;
  logic [EMIT_BITS-1:0]        fe_m1_w;

  lir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .src_rate (src_rate),
    .tgt_rate (tgt_rate),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign q_pop     = (state_r == B_IDLE) && q_valid;
  assign div_start = q_pop && (q_item.idx == '0);

  assign frac_w     = $signed({1'b0, rp_r[FRAC_BITS-1:0]});
  assign want_w     = k_r - 1'b1;
  assign pos_hit_w  = (rp_r[POS_BITS-1:FRAC_BITS] == want_w);
  assign held_ok_w  = fe_zero_r || (prod_a_r < PROD_A_BITS'(prod_b_r));
  assign cap_ok_w   = (n_r < RESULT_CNT_BITS'(RESULT_CAP));
  assign can_load_w = !out_valid_r || !out_stall;
  assign push_ok_w  = !pend_valid_r || can_load_w;
  assign fe_m1_w    = fe_r - 1'b1;
  // The held result moves to the output register in these states.
  assign out_load_w = pend_valid_r && push_ok_w &&
                      (state_r == B_LOUT || state_r == B_HOUT || state_r == B_FIN);

  // Interpolation lanes: floor((hi - lo) * frac >> 32) is an arithmetic shift.
  always_comb begin
    logic signed [17:0] mix;
    logic signed [17:0] part;
    for (int c = 0; c < LANES; c++) begin
      diff_w[c] = $signed({cur_r[c][15], cur_r[c]}) - $signed({prev_r[c][15], prev_r[c]});
      mult_w[c] = diff_w[c] * frac_w;
      part      = lane_r[c][49:FRAC_BITS];
      mix       = $signed({{2{prev_r[c][15]}}, prev_r[c]}) + part;
      if (4'(c) >= chans) begin
        res_w[c] = '0;
      end else if (state_r == B_HOUT) begin
        res_w[c] = cur_r[c];
      end else if (mix < SAMPLE_MIN) begin
        res_w[c] = SAMPLE_MIN[15:0];
      end else if (mix > SAMPLE_MAX) begin
        res_w[c] = SAMPLE_MAX[15:0];
      end else begin
        res_w[c] = mix[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_LMUL) begin
      for (int c = 0; c < LANES; c++) begin
        lane_r[c] <= mult_w[c];
      end
    end
    if (state_r == B_IMUL || state_r == B_HMUL) begin
      prod_a_r  <= PROD_A_BITS'(fe_m1_w * src_rate);
      prod_b_r  <= PROD_B_BITS'(k_r * tgt_rate);
      fe_zero_r <= (fe_r == '0);
    end
    if (q_pop) begin
      for (int c = 0; c < LANES; c++) begin
        cur_r[c] <= $signed(q_item.ch[c]);
      end
      fin_r <= q_item.fin;
      k_r   <= q_item.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= B_IDLE;
      pend_valid_r    <= 1'b0;
      out_valid_r     <= 1'b0;
      out_run_last_r  <= 1'b0;
      out_clip_done_r <= 1'b0;
      n_r             <= '0;
      rp_r            <= '0;
      step_r          <= '0;
      fe_r            <= '0;
      for (int c = 0; c < LANES; c++) begin
        prev_r[c] <= '0;
      end
    end else begin
      if (out_load_w) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            n_r     <= '0;
            state_r <= (q_item.idx == '0) ? B_DIV : B_IMUL;
          end
        end
        B_DIV: begin
          if (div_done) begin
            step_r  <= div_quot;
            state_r <= fin_r ? B_HMUL : B_FIN;
          end
        end
        B_IMUL: state_r <= B_ITEST;
        B_ITEST: begin
          if (cap_ok_w && pos_hit_w && (!fin_r || held_ok_w)) begin
            state_r <= B_LMUL;
          end else begin
            state_r <= fin_r ? B_HMUL : B_FIN;
          end
        end
        B_LMUL: state_r <= B_LOUT;
        B_HMUL: state_r <= B_HTEST;
        B_HTEST: state_r <= (cap_ok_w && held_ok_w) ? B_HOUT : B_FIN;
        B_LOUT, B_HOUT: begin
          // Hold one result back so the last of the item can be flagged.
          if (push_ok_w) begin
            if (pend_valid_r) begin
              out_data_r      <= pend_r;
              out_run_last_r  <= 1'b0;
              out_clip_done_r <= 1'b0;
            end
            pend_r       <= res_w;
            pend_valid_r <= 1'b1;
            rp_r         <= rp_r + POS_BITS'(step_r);
            fe_r         <= fe_r + 1'b1;
            n_r          <= n_r + 1'b1;
            state_r      <= (state_r == B_LOUT) ? B_IMUL : B_HMUL;
          end
        end
        B_FIN: begin
          if (push_ok_w) begin
            if (pend_valid_r) begin
              out_data_r      <= pend_r;
              out_run_last_r  <= 1'b1;
              out_clip_done_r <= fin_r;
            end
            pend_valid_r <= 1'b0;
            for (int c = 0; c < LANES; c++) begin
              prev_r[c] <= cur_r[c];
            end
            if (fin_r) begin
              rp_r <= '0;
              fe_r <= '0;
            end
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_run_last  = out_run_last_r;
  assign out_clip_done = out_clip_done_r;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import lir_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_FRAMES = 155;
  localparam int MAX_PRINTED   = 40;

  typedef struct packed {
    lir_frame_t ch;
    logic       run_last;
    logic       clip_done;
  } out_frame_t;

  typedef enum logic [1:0] {SHAPE_RANDOM, SHAPE_SMOOTH, SHAPE_SWING} frame_shape_t;
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [REG_IDX_BITS+1:0] paddr = '0;
  logic [31:0]             pwdata = '0;
  wire  [31:0]             prdata;
  wire                     pready;

  logic       in_valid = 1'b0;
  wire        in_stall;
  lir_frame_t drv_frame = '0;
  logic       drv_fin = 1'b0;

  wire                                  out_valid;
  logic                                 out_stall = 1'b0;
  wire [LANES-1:0][SAMPLE_BITS-1:0]     got_frame;
  wire                                  got_run_last;
  wire                                  got_clip_done;

  // Mirror of the block: registers and clip state
  logic [SRC_BITS-1:0]         reg_src = SRC_BITS'(44100);
  logic [TGT_BITS-1:0]         reg_tgt = TGT_BITS'(48000);
  logic [CHN_BITS-1:0]         reg_chans = CHN_BITS'(2);
  lir_frame_t                  prev_samples = '0;
  logic [POS_BITS-1:0]         out_pos = '0;
  logic [STEP_BITS-1:0]        pos_step = '0;
  logic [FRAME_COUNT_BITS-1:0] clip_frames = '0;
  logic [EMIT_BITS-1:0]        clip_outputs = '0;

  out_frame_t expected_frames[$];
  lir_frame_t last_drawn = '0;

  int errors = 0;
  int frames_sent = 0;
  int clips_sent = 0;
  int outputs_checked = 0;
  int reg_writes = 0;
  int burst_left = 0;
  int cycle_count = 0;

  rx_mode_t  rx_mode = RX_FREE;
  int        rx_left = 0;
  logic [7:0] rx_tick = '0;

  linear_interp_resampler i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_ch0        (drv_frame[0]),
    .in_ch1        (drv_frame[1]),
    .in_ch2        (drv_frame[2]),
    .in_ch3        (drv_frame[3]),
    .in_ch4        (drv_frame[4]),
    .in_ch5        (drv_frame[5]),
    .in_ch6        (drv_frame[6]),
    .in_ch7        (drv_frame[7]),
    .in_final_frame(drv_fin),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ch0       (got_frame[0]),
    .out_ch1       (got_frame[1]),
    .out_ch2       (got_frame[2]),
    .out_ch3       (got_frame[3]),
    .out_ch4       (got_frame[4]),
    .out_ch5       (got_frame[5]),
    .out_ch6       (got_frame[6]),
    .out_ch7       (got_frame[7]),
    .out_run_last  (got_run_last),
    .out_clip_done (got_clip_done)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d outputs still pending", cycle_count,
               expected_frames.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] clamp_rate(logic [63:0] v, logic [63:0] lo,
                                             logic [63:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // lo + (hi - lo) * frac / 2^32, floor, saturated to int16
  function automatic logic [15:0] interp_sample(logic signed [15:0] lo,
                                                logic signed [15:0] hi,
                                                logic [31:0] frac);
    longint     diff;
    longint     part;
    longint     mix;
    logic [63:0] prod;
    diff = longint'(hi) - longint'(lo);
    if (diff >= 0) begin
      prod = 64'(diff) * {32'd0, frac};
      part = longint'(prod >> FRAC_BITS);
    end else begin
      prod = 64'(-diff) * {32'd0, frac};
      part = -longint'((prod + 64'hFFFF_FFFF) >> FRAC_BITS);
    end
    mix = longint'(lo) + part;
    if (mix < longint'(SAMPLE_MIN)) mix = longint'(SAMPLE_MIN);
    if (mix > longint'(SAMPLE_MAX)) mix = longint'(SAMPLE_MAX);
    return mix[15:0];
  endfunction

  function automatic bit held_more(logic [EMIT_BITS-1:0] idx,
                                   logic [FRAME_COUNT_BITS-1:0] last,
                                   logic [63:0] s, logic [63:0] t);
    if (idx == 0) return 1'b1;
    return ((64'(idx) - 64'd1) * s) < (64'(last) * t);
  endfunction

  function automatic out_frame_t make_output(lir_frame_t vals, logic [63:0] chans);
    out_frame_t r;
    r = '0;
    for (int c = 0; c < LANES; c++)
      if (c < chans) r.ch[c] = vals[c];
    out_pos      = out_pos + POS_BITS'(pos_step);
    clip_outputs = clip_outputs + 1'b1;
    return r;
  endfunction

  function automatic void predict_frame(lir_frame_t cur, logic fin);
    logic [63:0]                 s;
    logic [63:0]                 t;
    logic [63:0]                 chans;
    logic [FRAME_COUNT_BITS-1:0] k;
    lir_frame_t                  vals;
    out_frame_t                  batch[$];
    out_frame_t                  tail;
    s     = clamp_rate(64'(reg_src), 64'(SRC_RATE_MIN), 64'(SRC_RATE_MAX));
    t     = clamp_rate(64'(reg_tgt), 64'(TGT_RATE_MIN), 64'(TGT_RATE_MAX));
    chans = clamp_rate(64'(reg_chans), 64'd1, 64'(MAX_CHANNELS));
    k     = clip_frames;
    if (k == 0) pos_step = STEP_BITS'((s << FRAC_BITS) / t);
    // interpolated outputs sitting between the previous frame and this one
    if (k != 0) begin
      while (batch.size() < RESULT_CAP &&
             out_pos[POS_BITS-1:FRAC_BITS] == FRAME_COUNT_BITS'(k - 1'b1) &&
             (!fin || held_more(clip_outputs, k, s, t))) begin
        for (int c = 0; c < LANES; c++)
          vals[c] = interp_sample(prev_samples[c], cur[c], out_pos[FRAC_BITS-1:0]);
        batch.push_back(make_output(vals, chans));
      end
    end
    // held-end copies of the last frame
    if (fin) begin
      while (batch.size() < RESULT_CAP && held_more(clip_outputs, k, s, t))
        batch.push_back(make_output(cur, chans));
    end
    if (batch.size() > 0) begin
      tail = batch.pop_back();
      tail.run_last  = 1'b1;
      tail.clip_done = fin;
      batch.push_back(tail);
    end
    foreach (batch[i]) expected_frames.push_back(batch[i]);
    prev_samples = cur;
    if (fin) begin
      clip_frames  = '0;
      clip_outputs = '0;
      out_pos      = '0;
    end else begin
      clip_frames = clip_frames + 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("[%0t] output %0d: %s got %h, want %h", $time, outputs_checked, field,
               got, want);
  endtask

  always @(posedge clk) begin
    out_frame_t want_v;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected output frame", got_frame[0], '0);
      end else begin
        want_v = expected_frames.pop_front();
        for (int c = 0; c < LANES; c++)
          if (got_frame[c] !== want_v.ch[c])
            report_mismatch($sformatf("ch%0d", c), got_frame[c], want_v.ch[c]);
        if (got_run_last !== want_v.run_last)
          report_mismatch("run_last", 16'(got_run_last), 16'(want_v.run_last));
        if (got_clip_done !== want_v.clip_done)
          report_mismatch("clip_done", 16'(got_clip_done), 16'(want_v.clip_done));
      end
      outputs_checked++;
    end
  end

  // receiver back-pressure, switching between patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_mode   <= RX_FREE;
      rx_left   <= 100;
      rx_tick   <= '0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(30, 300);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ((rx_tick % 7) < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IN_RATE:       reg_src   = value[SRC_BITS-1:0];
      REG_OUT_RATE:      reg_tgt   = value[TGT_BITS-1:0];
      REG_CHANNEL_COUNT: reg_chans = value[CHN_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_rates(logic [31:0] src, logic [31:0] tgt, logic [31:0] chans);
    write_reg(REG_IN_RATE, src);
    write_reg(REG_OUT_RATE, tgt);
    write_reg(REG_CHANNEL_COUNT, chans);
  endtask

  // hold off until every expected output is out, plus time for silent items
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic send_frame(lir_frame_t frame, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_valid  <= 1'b1;
    drv_frame <= frame;
    drv_fin   <= fin;
    do @(posedge clk); while (in_stall);
    burst_left--;
    predict_frame(frame, fin);
    frames_sent++;
  endtask

  function automatic lir_frame_t draw_frame(frame_shape_t shape, int idx);
    lir_frame_t f;
    for (int c = 0; c < LANES; c++) begin
      case (shape)
        SHAPE_SMOOTH: f[c] = last_drawn[c] + 16'($urandom_range(0, 1024)) - 16'd512;
        SHAPE_SWING:  f[c] = ((idx + c) % 2 != 0) ? 16'h7FFF : 16'h8000;
        default:      f[c] = 16'($urandom);
      endcase
    end
    last_drawn = f;
    return f;
  endfunction

  task automatic play_clip(int len, frame_shape_t shape);
    for (int i = 0; i < len; i++)
      send_frame(draw_frame(shape, i), i == len - 1);
    clips_sent++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    play_clip(3, SHAPE_RANDOM);
  endtask

  task automatic test_equal_rates();
    settle();
    set_rates(48000, 48000, 8);
    play_clip(3, SHAPE_RANDOM);
  endtask

  task automatic test_single_frame();
    settle();
    set_rates(8000, 48000, 3);
    play_clip(1, SHAPE_RANDOM);
    play_clip(1, SHAPE_SWING);
  endtask

  // full-scale steps at the widest upsampling ratio
  task automatic test_full_swing();
    settle();
    set_rates(8000, 48000, 8);
    play_clip(4, SHAPE_SWING);
  endtask

  task automatic test_channel_limits();
    settle();
    set_rates(44100, 22050, 1);
    play_clip(2, SHAPE_RANDOM);
    settle();
    write_reg(REG_CHANNEL_COUNT, 0);
    play_clip(2, SHAPE_RANDOM);
    settle();
    write_reg(REG_CHANNEL_COUNT, 15);
    play_clip(1, SHAPE_SWING);
  endtask

  // out-of-range register values are clamped by the block
  task automatic test_register_clamping();
    settle();
    set_rates(0, 32'h0000_FFFF, 8);
    play_clip(2, SHAPE_RANDOM);
    settle();
    set_rates(32'hFFFF_FFFF, 0, 4);
    play_clip(2, SHAPE_RANDOM);
  endtask

  // step stays latched; held-end test sees the new rates
  task automatic test_rate_change_mid_clip();
    settle();
    set_rates(32000, 48000, 2);
    send_frame(draw_frame(SHAPE_RANDOM, 0), 1'b0);
    send_frame(draw_frame(SHAPE_RANDOM, 1), 1'b0);
    settle();
    set_rates(96000, 16000, 2);
    send_frame(draw_frame(SHAPE_SMOOTH, 2), 1'b0);
    send_frame(draw_frame(SHAPE_SMOOTH, 3), 1'b1);
    clips_sent++;
  endtask

  task automatic randomize_regs();
    logic [31:0] src;
    logic [31:0] tgt;
    logic [31:0] chans;
    case ($urandom_range(0, 15))
      0:       src = 8000;
      1:       src = 192000;
      2:       src = $urandom_range(0, (1 << SRC_BITS) - 1);
      default: src = $urandom_range(8000, 192000);
    endcase
    case ($urandom_range(0, 15))
      0:       tgt = 8000;
      1:       tgt = 48000;
      2:       tgt = $urandom_range(0, (1 << TGT_BITS) - 1);
      default: tgt = $urandom_range(8000, 48000);
    endcase
    chans = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
    set_rates(src, tgt, chans);
  endtask

  task automatic test_random_clips();
    int start;
    int len;
    start = frames_sent;
    while (frames_sent - start < RANDOM_FRAMES) begin
      if ($urandom_range(0, 1) == 0) begin
        settle();
        randomize_regs();
      end
      case ($urandom_range(0, 7))
        0:       len = 1;
        1:       len = $urandom_range(12, 24);
        default: len = $urandom_range(2, 10);
      endcase
      play_clip(len, frame_shape_t'($urandom_range(0, 2)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_equal_rates();
    test_single_frame();
    test_full_swing();
    test_channel_limits();
    test_register_clamping();
    test_rate_change_mid_clip();
    test_random_clips();

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d frames in %0d clips over %0d register writes;", frames_sent,
             clips_sent, reg_writes);
    $display("checked %0d resampled frames, %0d field errors.", outputs_checked, errors);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
